// File: rtl/strip_cluster_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// Strip cluster finder assertion macros
// Wrappers for the concurrent checks of the cluster finder queue.
// ----------------------------------------------------------------------------
`ifndef STRIP_CLUSTER_FINDER_UNIT_MACROS_SVH
`define STRIP_CLUSTER_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("strip cluster finder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("strip cluster finder: assertion failed");

`endif

// File: rtl/scf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strip cluster finder package
// Widths, cuts, register indexes and shared types of the cluster finder.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int MAX_STRIPS   = 1024;
    localparam int NUM_LAYERS   = 6;
    localparam int SIZE_CUT_X   = 1;
    localparam int SIZE_CUT_Y   = 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam int LAYER_W      = 3;
    localparam int STRIP_W      = 10;
    localparam int AMP_W        = 13;
    localparam int MAG_W        = 12;
    localparam int SIZE_W       = 11;
    localparam int SUM_W        = 22;
    localparam int WSUM_W       = 32;
    localparam int PROD_W       = STRIP_W + MAG_W;
    localparam int CEN_W        = 18;
    localparam int FRAC_BITS    = 8;
    localparam int DIV_CNT_W    = $clog2(CEN_W);

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 22;
    localparam int NUM_AMP_CUTS = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_CUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_CUT_0  = 3'd1;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [SIZE_W-1:0]  size;
        logic [SUM_W-1:0]   sum;
        logic [WSUM_W-1:0]  wsum;
        logic [MAG_W-1:0]   peak;
        logic               last_of_run;
    } t_cluster_rec;

    typedef struct packed {
        logic empty;
        logic room_for_two;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_HOLD
    } t_back_state;

endpackage
`default_nettype wire

// File: rtl/scf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strip cluster finder front end
// Holds the cuts, builds the open cluster and queues the clusters that pass.
// ----------------------------------------------------------------------------
module scf_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [scf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [scf_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [scf_pkg::LAYER_W-1:0]            i_layer,
    input  logic                                   i_is_y,
    input  logic [scf_pkg::STRIP_W-1:0]            i_strip,
    input  logic signed [scf_pkg::AMP_W-1:0]       i_amplitude,
    input  logic                                   i_last,
    input  scf_pkg::t_queue_status                 i_q_status,
    output logic [1:0]                             o_push_count,
    output scf_pkg::t_cluster_rec                  o_rec0,
    output scf_pkg::t_cluster_rec                  o_rec1
);
    import scf_pkg::*;

    logic [MAG_W-1:0]  r_signal_cut;
    logic [SUM_W-1:0]  r_amp_cut [NUM_AMP_CUTS];
    logic [SIZE_W-1:0] r_open_size;
    logic [SUM_W-1:0]  r_open_sum;
    logic [WSUM_W-1:0] r_open_wsum;
    logic [MAG_W-1:0]  r_open_peak;
    logic [STRIP_W-1:0] r_last_strip;

    logic [SIZE_W-1:0]  n_open_size;
    logic [SUM_W-1:0]   n_open_sum;
    logic [WSUM_W-1:0]  n_open_wsum;
    logic [MAG_W-1:0]   n_open_peak;
    logic [STRIP_W-1:0] n_last_strip;

    logic [SIZE_W-1:0]  upd_size;
    logic [SUM_W-1:0]   upd_sum;
    logic [WSUM_W-1:0]  upd_wsum;
    logic [MAG_W-1:0]   upd_peak;
    logic [STRIP_W-1:0] upd_last_strip;

    logic               accept_word;
    logic [MAG_W-1:0]   mag;
    logic [PROD_W-1:0]  prod;
    logic               amp_ok;
    logic               strip_ok;
    logic               is_open;
    logic               take;
    logic               adjacent;
    logic               extend;
    logic               restart;
    logic               gap_close;
    logic               layer_ok;
    logic [SUM_W-1:0]   sel_amp_cut;
    logic [SIZE_W-1:0]  size_cut;
    logic               pass_gap;
    logic               pass_last;
    t_cluster_rec       rec_gap;
    t_cluster_rec       rec_last;

    assign o_ready     = i_q_status.room_for_two;
    assign accept_word = i_valid && o_ready;

    assign mag      = i_amplitude[MAG_W-1:0];
    assign prod     = PROD_W'(i_strip) * PROD_W'(mag);
    assign amp_ok   = !i_amplitude[AMP_W-1] && (mag >= r_signal_cut);
    assign strip_ok = 32'(i_strip) < 32'(MAX_STRIPS);
    assign is_open  = r_open_size != '0;
    assign take     = amp_ok && strip_ok && (!is_open || (i_strip > r_last_strip));
    assign adjacent = ({1'b0, i_strip} == ({1'b0, r_last_strip} + (STRIP_W+1)'(1))) ||
                      ({1'b0, i_strip} == ({1'b0, r_last_strip} + (STRIP_W+1)'(2)));
    assign extend    = take && is_open && adjacent;
    assign restart   = take && !(is_open && adjacent);
    assign gap_close = take && is_open && !adjacent;

    always_comb begin
        sel_amp_cut = '0;
        for (int k = 0; k < NUM_AMP_CUTS; k++) begin
            if (i_layer == LAYER_W'(k)) begin
                sel_amp_cut = r_amp_cut[k];
            end
        end
    end

    assign layer_ok = 32'(i_layer) < 32'(NUM_LAYERS);
    assign size_cut = i_is_y ? SIZE_W'(SIZE_CUT_Y) : SIZE_W'(SIZE_CUT_X);

    always_comb begin
        upd_size       = r_open_size;
        upd_sum        = r_open_sum;
        upd_wsum       = r_open_wsum;
        upd_peak       = r_open_peak;
        upd_last_strip = r_last_strip;
        if (restart) begin
            upd_size       = SIZE_W'(1);
            upd_sum        = SUM_W'(mag);
            upd_wsum       = WSUM_W'(prod);
            upd_peak       = mag;
            upd_last_strip = i_strip;
        end else if (extend) begin
            upd_size       = r_open_size + SIZE_W'(1);
            upd_sum        = r_open_sum + SUM_W'(mag);
            upd_wsum       = r_open_wsum + WSUM_W'(prod);
            upd_peak       = (mag > r_open_peak) ? mag : r_open_peak;
            upd_last_strip = i_strip;
        end
    end

    assign pass_gap  = gap_close && layer_ok && (r_open_size > size_cut) &&
                       (r_open_sum > sel_amp_cut);
    assign pass_last = i_last && (upd_size != '0) && layer_ok && (upd_size > size_cut) &&
                       (upd_sum > sel_amp_cut);

    always_comb begin
        rec_gap.layer        = i_layer;
        rec_gap.size         = r_open_size;
        rec_gap.sum          = r_open_sum;
        rec_gap.wsum         = r_open_wsum;
        rec_gap.peak         = r_open_peak;
        rec_gap.last_of_run  = !pass_last;
        rec_last.layer       = i_layer;
        rec_last.size        = upd_size;
        rec_last.sum         = upd_sum;
        rec_last.wsum        = upd_wsum;
        rec_last.peak        = upd_peak;
        rec_last.last_of_run = 1'b1;
    end

    always_comb begin
        o_push_count = 2'd0;
        o_rec0       = rec_gap;
        o_rec1       = rec_last;
        if (accept_word) begin
            if (pass_gap && pass_last) begin
                o_push_count = 2'd2;
            end else if (pass_gap) begin
                o_push_count = 2'd1;
            end else if (pass_last) begin
                o_push_count = 2'd1;
                o_rec0       = rec_last;
            end
        end
    end

    always_comb begin
        n_open_size  = r_open_size;
        n_open_sum   = r_open_sum;
        n_open_wsum  = r_open_wsum;
        n_open_peak  = r_open_peak;
        n_last_strip = r_last_strip;
        if (accept_word) begin
            if (i_last) begin
                n_open_size  = '0;
                n_open_sum   = '0;
                n_open_wsum  = '0;
                n_open_peak  = '0;
                n_last_strip = '0;
            end else begin
                n_open_size  = upd_size;
                n_open_sum   = upd_sum;
                n_open_wsum  = upd_wsum;
                n_open_peak  = upd_peak;
                n_last_strip = upd_last_strip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_cut <= '0;
            for (int k = 0; k < NUM_AMP_CUTS; k++) begin
                r_amp_cut[k] <= '0;
            end
            r_open_size  <= '0;
            r_open_sum   <= '0;
            r_open_wsum  <= '0;
            r_open_peak  <= '0;
            r_last_strip <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SIGNAL_CUT) begin
                    r_signal_cut <= i_cfg_data[MAG_W-1:0];
                end
                for (int k = 0; k < NUM_AMP_CUTS; k++) begin
                    if (i_cfg_idx == CFG_AMP_CUT_0 + CFG_IDX_W'(k)) begin
                        r_amp_cut[k] <= i_cfg_data[SUM_W-1:0];
                    end
                end
            end
            r_open_size  <= n_open_size;
            r_open_sum   <= n_open_sum;
            r_open_wsum  <= n_open_wsum;
            r_open_peak  <= n_open_peak;
            r_last_strip <= n_last_strip;
        end
    end

endmodule
`default_nettype wire

// File: rtl/scf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "strip_cluster_finder_unit_macros.svh"
// ----------------------------------------------------------------------------
// Strip cluster finder cluster queue
// Short queue of closed clusters, taking up to two words per cycle.
// ----------------------------------------------------------------------------
module scf_queue #(
    parameter int DEPTH = scf_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_count,
    input  scf_pkg::t_cluster_rec  i_rec0,
    input  scf_pkg::t_cluster_rec  i_rec1,
    input  logic                   i_pop,
    output scf_pkg::t_cluster_rec  o_head,
    output scf_pkg::t_queue_status o_status
);
    import scf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cluster_rec     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wptr_second;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        res = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        return res;
    endfunction

    assign wptr_second = ptr_inc(r_wptr);
    assign o_head      = r_mem[r_rptr];

    assign o_status.empty        = r_count == '0;
    assign o_status.room_for_two = r_count <= CNT_W'(DEPTH - 2);

    always_comb begin
        n_wptr = r_wptr;
        case (i_push_count)
            2'd1:    n_wptr = wptr_second;
            2'd2:    n_wptr = ptr_inc(wptr_second);
            default: n_wptr = r_wptr;
        endcase
        n_rptr  = i_pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + CNT_W'(i_push_count) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wptr] <= i_rec0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wptr_second] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `SCF_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push_count != 2'd0, (32'(r_count) + 32'(i_push_count)) <= 32'(DEPTH))
    `SCF_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `SCF_ASSERT_NEXT(a_count_tracks, i_clk, i_rst_n, 1'b1, r_count == CNT_W'($past(r_count) + CNT_W'($past(i_push_count)) - CNT_W'($past(i_pop))))

endmodule
`default_nettype wire

// File: rtl/scf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strip cluster finder back end
// Divides each queued cluster for its centroid and holds the result word.
// ----------------------------------------------------------------------------
module scf_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  scf_pkg::t_cluster_rec           i_head,
    input  scf_pkg::t_queue_status          i_q_status,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [scf_pkg::LAYER_W-1:0]     o_out_layer,
    output logic [scf_pkg::SIZE_W-1:0]      o_strip_count,
    output logic [scf_pkg::SUM_W-1:0]       o_total_amplitude,
    output logic [scf_pkg::MAG_W-1:0]       o_peak_amplitude,
    output logic [scf_pkg::CEN_W-1:0]       o_centroid,
    output logic                            o_last_of_run
);
    import scf_pkg::*;

    localparam int HI_W = CEN_W - FRAC_BITS;

    t_back_state         r_state;
    t_back_state         n_state;
    t_cluster_rec        r_work;
    logic [SUM_W-1:0]    r_rem;
    logic [CEN_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic                r_out_valid;
    logic [LAYER_W-1:0]  r_out_layer;
    logic [SIZE_W-1:0]   r_out_size;
    logic [SUM_W-1:0]    r_out_sum;
    logic [MAG_W-1:0]    r_out_peak;
    logic [CEN_W-1:0]    r_out_cen;
    logic                r_out_last;

    logic                out_free;
    logic                do_step;
    logic                load_out;
    logic                last_step;
    logic [SUM_W:0]      trial;
    logic                trial_ge;
    logic [SUM_W-1:0]    step_rem;

    assign out_free  = !r_out_valid || i_ready;
    assign last_step = r_cnt == DIV_CNT_W'(CEN_W - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:   if (!i_q_status.empty) n_state = BK_DIVIDE;
            BK_DIVIDE: if (last_step) n_state = BK_HOLD;
            BK_HOLD:   if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE:   o_pop    = !i_q_status.empty;
            BK_DIVIDE: do_step  = 1'b1;
            BK_HOLD:   load_out = out_free;
            default:   o_pop    = 1'b0;
        endcase
    end

    assign trial    = {r_rem, r_quo[CEN_W-1]};
    assign trial_ge = trial >= {1'b0, r_work.sum};
    assign step_rem = trial_ge ? SUM_W'(trial - {1'b0, r_work.sum}) : SUM_W'(trial);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head;
            r_rem  <= i_head.wsum[WSUM_W-1:HI_W];
            r_quo  <= {i_head.wsum[HI_W-1:0], FRAC_BITS'(0)};
            r_cnt  <= '0;
        end else if (do_step) begin
            r_rem  <= step_rem;
            r_quo  <= {r_quo[CEN_W-2:0], trial_ge};
            r_cnt  <= r_cnt + DIV_CNT_W'(1);
        end
        if (load_out) begin
            r_out_layer <= r_work.layer;
            r_out_size  <= r_work.size;
            r_out_sum   <= r_work.sum;
            r_out_peak  <= r_work.peak;
            r_out_cen   <= r_quo;
            r_out_last  <= r_work.last_of_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_layer       = r_out_layer;
    assign o_strip_count     = r_out_size;
    assign o_total_amplitude = r_out_sum;
    assign o_peak_amplitude  = r_out_peak;
    assign o_centroid        = r_out_cen;
    assign o_last_of_run     = r_out_last;

endmodule
`default_nettype wire

// File: rtl/strip_cluster_finder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strip cluster finder
// Groups neighboring strip hits of a layer into clusters and reports each
// cluster that passes the size and amplitude cuts with its centroid.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Word
//  input     in         i_valid / o_ready    one strip hit
//  output    out        o_valid / i_ready    one cluster
//  config    in         i_cfg_we             one register write, no wait
//
//  The front end takes one strip hit per cycle while the queue has room for two clusters.
//  Each reported cluster passes the back end in order: a load from the queue, the 18 steps of its
//  one-bit-per-cycle centroid divider, and a hand-off to the output register once that is free.
//  Synchronous reset clears the cuts, the open cluster and the queue.
//  A stalled output word is held while the back end divides the next cluster.
// ----------------------------------------------------------------------------
module strip_cluster_finder_unit #(
    parameter int QUEUE_DEPTH = scf_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [scf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [scf_pkg::LAYER_W-1:0]      i_layer,
    input  logic                             i_is_y,
    input  logic [scf_pkg::STRIP_W-1:0]      i_strip,
    input  logic signed [scf_pkg::AMP_W-1:0] i_amplitude,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [scf_pkg::LAYER_W-1:0]      o_out_layer,
    output logic [scf_pkg::SIZE_W-1:0]       o_strip_count,
    output logic [scf_pkg::SUM_W-1:0]        o_total_amplitude,
    output logic [scf_pkg::MAG_W-1:0]        o_peak_amplitude,
    output logic [scf_pkg::CEN_W-1:0]        o_centroid,
    output logic                             o_last_of_run
);
    import scf_pkg::*;

    t_queue_status q_status;
    t_cluster_rec  push_rec0;
    t_cluster_rec  push_rec1;
    t_cluster_rec  head_rec;
    logic [1:0]    push_count;
    logic          pop;

    scf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_layer      (i_layer),
        .i_is_y       (i_is_y),
        .i_strip      (i_strip),
        .i_amplitude  (i_amplitude),
        .i_last       (i_last),
        .i_q_status   (q_status),
        .o_push_count (push_count),
        .o_rec0       (push_rec0),
        .o_rec1       (push_rec1)
    );

    scf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_rec0       (push_rec0),
        .i_rec1       (push_rec1),
        .i_pop        (pop),
        .o_head       (head_rec),
        .o_status     (q_status)
    );

    scf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head_rec),
        .i_q_status        (q_status),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_layer       (o_out_layer),
        .o_strip_count     (o_strip_count),
        .o_total_amplitude (o_total_amplitude),
        .o_peak_amplitude  (o_peak_amplitude),
        .o_centroid        (o_centroid),
        .o_last_of_run     (o_last_of_run)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strip cluster finder testbench
// Feeds layer scans of strip hits plus random noise hits through the cluster
// finder under several cut settings. A scoreboard rebuilds the clusters, the
// cuts and the centroids independently and checks every cluster word the
// block reports, in order.
// ----------------------------------------------------------------------------
module tb;

    import scf_pkg::*;

    localparam int IDLE_PCT       = 37;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_HITS     = 205;
    localparam int NUM_PHASES     = 5;
    localparam int AMP_CUT_MAX    = 4193280;

    typedef struct {
        bit [LAYER_W-1:0]      layer;
        bit                    is_y;
        bit [STRIP_W-1:0]      strip;
        bit signed [AMP_W-1:0] amplitude;
        bit                    last;
    } t_hit;

    typedef struct {
        logic [LAYER_W-1:0] layer;
        logic [SIZE_W-1:0]  size;
        logic [SUM_W-1:0]   sum;
        logic [MAG_W-1:0]   peak;
        logic [CEN_W-1:0]   centroid;
        logic               last_of_run;
    } t_cluster;

    class t_cluster_tracker;
        int          signal_cut;
        int unsigned amp_cut [NUM_AMP_CUTS];
        int          run_size;
        int unsigned run_sum;
        longint      run_wsum;
        int          run_peak;
        int          prev_strip;
        t_cluster    pending [$];
        int          mismatches;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
            if (idx == CFG_SIGNAL_CUT) begin
                signal_cut = int'(val & 32'hFFF);
            end else begin
                amp_cut[idx - CFG_AMP_CUT_0] = val & 32'h3FFFFF;
            end
        endfunction

        function void start_run(int strip, int amp);
            run_size   = 1;
            run_sum    = amp;
            run_wsum   = longint'(strip) * amp;
            run_peak   = amp;
            prev_strip = strip;
        endfunction

        function int close_run(bit [LAYER_W-1:0] layer, bit is_y);
            t_cluster want;
            int       size_cut;
            longint   cen;
            int       made;
            made = 0;
            size_cut = is_y ? SIZE_CUT_Y : SIZE_CUT_X;
            if (run_size != 0 && layer < NUM_LAYERS && run_size > size_cut &&
                run_sum > amp_cut[layer]) begin
                cen = (run_sum != 0) ? (run_wsum << FRAC_BITS) / run_sum : 0;
                want.layer       = layer;
                want.size        = SIZE_W'(run_size);
                want.sum         = SUM_W'(run_sum);
                want.peak        = MAG_W'(run_peak);
                want.centroid    = CEN_W'(cen);
                want.last_of_run = 1'b0;
                pending.insert(pending.size(), want);
                made = 1;
            end
            run_size = 0;
            run_sum  = 0;
            run_wsum = 0;
            run_peak = 0;
            return made;
        endfunction

        function void take_hit(t_hit h);
            int amp_val;
            int strip;
            bit keep;
            int made;
            made    = 0;
            amp_val = int'(h.amplitude);
            strip   = int'(h.strip);
            keep    = amp_val >= signal_cut && strip < MAX_STRIPS;
            if (keep && run_size != 0 && strip <= prev_strip) begin
                keep = 1'b0;
            end
            if (keep) begin
                if (run_size == 0) begin
                    start_run(strip, amp_val);
                end else if (strip == prev_strip + 1 || strip == prev_strip + 2) begin
                    run_size++;
                    run_sum  += amp_val;
                    run_wsum += longint'(strip) * amp_val;
                    if (amp_val > run_peak) begin
                        run_peak = amp_val;
                    end
                    prev_strip = strip;
                end else begin
                    made += close_run(h.layer, h.is_y);
                    start_run(strip, amp_val);
                end
            end
            if (h.last) begin
                made += close_run(h.layer, h.is_y);
                prev_strip = 0;
            end
            if (made > 0) begin
                pending[pending.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_cluster(t_cluster got);
            t_cluster want;
            if (pending.size() == 0) begin
                $error("unexpected cluster word on layer %0d", got.layer);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_layer", 32'(want.layer), 32'(got.layer));
            compare_field("strip_count", 32'(want.size), 32'(got.size));
            compare_field("total_amplitude", 32'(want.sum), 32'(got.sum));
            compare_field("peak_amplitude", 32'(want.peak), 32'(got.peak));
            compare_field("centroid", 32'(want.centroid), 32'(got.centroid));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [LAYER_W-1:0]     i_layer;
    logic                   i_is_y;
    logic [STRIP_W-1:0]     i_strip;
    logic signed [AMP_W-1:0] i_amplitude;
    logic                   i_last;
    logic                   o_valid;
    logic                   i_ready;
    logic [LAYER_W-1:0]     o_out_layer;
    logic [SIZE_W-1:0]      o_strip_count;
    logic [SUM_W-1:0]       o_total_amplitude;
    logic [MAG_W-1:0]       o_peak_amplitude;
    logic [CEN_W-1:0]       o_centroid;
    logic                   o_last_of_run;

    t_cluster_tracker tracker = new;
    bit             steady  = 1'b0;
    int             quiet_cycles = 0;
    int             signal_plan;
    int unsigned    amp_plan [NUM_AMP_CUTS];

    strip_cluster_finder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_layer           (i_layer),
        .i_is_y            (i_is_y),
        .i_strip           (i_strip),
        .i_amplitude       (i_amplitude),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_layer       (o_out_layer),
        .o_strip_count     (o_strip_count),
        .o_total_amplitude (o_total_amplitude),
        .o_peak_amplitude  (o_peak_amplitude),
        .o_centroid        (o_centroid),
        .o_last_of_run     (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic t_hit make_hit(int layer, int is_y, int strip, int amp, int last);
        t_hit h;
        h.layer     = LAYER_W'(layer);
        h.is_y      = is_y[0];
        h.strip     = STRIP_W'(strip);
        h.amplitude = AMP_W'(amp);
        h.last      = last[0];
        return h;
    endfunction

    function automatic t_hit noise_hit();
        return make_hit($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1023),
                        int'($urandom_range(0, 8191)) - 4096, $urandom_range(0, 7) == 0);
    endfunction

    function automatic int pick_amp();
        int r;
        int cut;
        cut = tracker.signal_cut;
        r   = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(cut, 4095);
        end
        if (r < 90 && cut > 0) begin
            return $urandom_range(0, cut - 1);
        end
        return -int'($urandom_range(1, 4096));
    endfunction

    task automatic send_hit(input t_hit h);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_layer     <= h.layer;
        i_is_y      <= h.is_y;
        i_strip     <= h.strip;
        i_amplitude <= h.amplitude;
        i_last      <= h.last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        tracker.take_hit(h);
    endtask

    task automatic load_cuts();
        for (int k = 0; k <= NUM_AMP_CUTS; k++) begin
            i_cfg_we <= 1'b1;
            if (k == 0) begin
                i_cfg_idx  <= CFG_SIGNAL_CUT;
                i_cfg_data <= CFG_DATA_W'(signal_plan);
                tracker.set_reg(CFG_SIGNAL_CUT, signal_plan);
            end else begin
                i_cfg_idx  <= CFG_AMP_CUT_0 + CFG_IDX_W'(k - 1);
                i_cfg_data <= CFG_DATA_W'(amp_plan[k - 1]);
                tracker.set_reg(CFG_AMP_CUT_0 + CFG_IDX_W'(k - 1), amp_plan[k - 1]);
            end
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One layer read out in strip order: mostly neighbors, some skipped strips,
    // repeats, steps back and gaps. A dense scan is one long unbroken cluster.
    task automatic scan_layer(input int hits, input bit dense, output int count);
        t_hit run [$];
        t_hit h;
        int   s;
        int   r;
        h.layer = LAYER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                       : $urandom_range(0, 5));
        h.is_y  = $urandom_range(0, 1);
        h.last  = 1'b0;
        s = dense ? $urandom_range(0, 800) : $urandom_range(0, 1000);
        for (int k = 0; k < hits && s <= 1023; k++) begin
            h.strip     = STRIP_W'(s);
            h.amplitude = AMP_W'(dense ? $urandom_range(tracker.signal_cut, 4095) : pick_amp());
            run.insert(run.size(), h);
            r = $urandom_range(0, 99);
            if (dense || r < 68) begin
                s += 1;
            end else if (r < 80) begin
                s += 2;
            end else if (r < 86) begin
                s = (s >= 2) ? s - int'($urandom_range(0, 2)) : s;
            end else begin
                s += $urandom_range(3, 40);
            end
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[k]) begin
            send_hit(run[k]);
        end
        count = run.size();
    endtask

    task automatic run_directed();
        send_hit(make_hit(0, 0, 0, 4095, 0));
        send_hit(make_hit(0, 0, 1, 4095, 0));
        send_hit(make_hit(0, 0, 3, 1, 0));
        send_hit(make_hit(0, 0, 3, 500, 0));
        send_hit(make_hit(0, 0, 2, 500, 0));
        send_hit(make_hit(0, 0, 10, -4096, 0));
        send_hit(make_hit(0, 0, 10, 7, 0));
        send_hit(make_hit(0, 0, 11, 0, 1));
        send_hit(make_hit(1, 1, 1023, 4095, 0));
        send_hit(make_hit(1, 1, 5, 20, 1));
        send_hit(make_hit(2, 1, 100, 200, 0));
        send_hit(make_hit(2, 1, 101, 300, 0));
        send_hit(make_hit(2, 1, 200, 400, 1));
        send_hit(make_hit(5, 0, 500, -1, 1));
        send_hit(make_hit(5, 0, 600, 10, 0));
        send_hit(make_hit(5, 0, 601, 20, 0));
        send_hit(make_hit(5, 0, 900, -5, 1));
        send_hit(make_hit(6, 0, 1, 100, 0));
        send_hit(make_hit(6, 0, 2, 100, 1));
        send_hit(make_hit(7, 1, 4, 100, 0));
        send_hit(make_hit(7, 1, 5, 100, 1));
        send_hit(make_hit(3, 1, 1022, 4095, 0));
        send_hit(make_hit(3, 1, 1023, 4095, 1));
        send_hit(make_hit(4, 0, 0, 0, 0));
        send_hit(make_hit(4, 0, 1, 0, 1));
    endtask

    initial begin
        t_cluster got;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                got.layer       = o_out_layer;
                got.size        = o_strip_count;
                got.sum         = o_total_amplitude;
                got.peak        = o_peak_amplitude;
                got.centroid    = o_centroid;
                got.last_of_run = o_last_of_run;
                tracker.match_cluster(got);
            end
        end
    end

    initial begin
        int fed;
        int count;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_SIGNAL_CUT;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_layer     <= '0;
        i_is_y      <= 1'b0;
        i_strip     <= '0;
        i_amplitude <= '0;
        i_last      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    signal_plan = 0;
                    foreach (amp_plan[k]) amp_plan[k] = 0;
                end
                1: begin
                    signal_plan = $urandom_range(1, 300);
                    foreach (amp_plan[k]) amp_plan[k] = $urandom_range(0, 12000);
                end
                2: begin
                    signal_plan = 4095;
                    foreach (amp_plan[k]) amp_plan[k] = 0;
                end
                3: begin
                    signal_plan = $urandom_range(0, 2000);
                    foreach (amp_plan[k]) begin
                        amp_plan[k] = (k % 2 == 0) ? AMP_CUT_MAX : $urandom_range(0, 12000);
                    end
                end
                default: begin
                    signal_plan = $urandom_range(0, 1000);
                    foreach (amp_plan[k]) amp_plan[k] = $urandom_range(0, 30000);
                end
            endcase
            load_cuts();
            steady = (p == 2);
            if (p == 0) begin
                run_directed();
            end
            fed = 0;
            while (fed < PHASE_HITS) begin
                if (p == NUM_PHASES - 1 && fed == 0) begin
                    scan_layer(120, 1'b1, count);
                    fed += count;
                end else if ($urandom_range(0, 99) < 20) begin
                    send_hit(noise_hit());
                    fed++;
                end else begin
                    scan_layer($urandom_range(3, 24), 1'b0, count);
                    fed += count;
                end
            end
            steady = 1'b0;
            drain();
        end

        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
